// File: sv/spanning_tree_bpdu_engine_defines.svh
// Assertion macros for the checker file.
`ifndef SPANNING_TREE_BPDU_ENGINE_DEFINES_SVH
`define SPANNING_TREE_BPDU_ENGINE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// Assert that an expression holds at every edge out of reset.
`define STB_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

// File: sv/stb_pkg.sv
// Shared types and constants of the spanning tree config message engine.
package stb_pkg;
	localparam int unsigned DefMaxPorts = 8;
	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_RX    = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BRIDGE_ID   = 3'd0,
		REG_PORT_PRIO   = 3'd1,
		REG_PATH_COST   = 3'd2,
		REG_PORTS_USE   = 3'd3,
		REG_HELLO_INTV  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  rx_port;
		logic [63:0] msg_root_id;
		logic [31:0] msg_root_cost;
		logic [63:0] msg_bridge_id;
		logic [15:0] msg_port_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  tx_port;
		logic [63:0] tx_root_id;
		logic [31:0] tx_root_cost;
		logic [63:0] tx_bridge_id;
		logic [15:0] tx_port_id;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [63:0]        data;
	} cfg_item_t;
endpackage

// File: sv/stb_if.sv
// Valid/ready channel interfaces of the engine.
interface stb_in_if;
	import stb_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface stb_out_if;
	import stb_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface stb_cfg_if;
	import stb_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/spanning_tree_bpdu_engine.sv
// Spanning tree configuration message engine, top level.
// One item is taken at a time; ready stays low while it is worked. A start item
// keeps the block busy while it writes the port table, one table row per cycle,
// for all MAX_PORTS rows. A tick steps the hello timer; when the timer expires it
// also walks the np active ports and sends. A received message that is not
// superior is compared and may be answered on its own port. For a superior one,
// one shared vector comparator walks the port table once to pick the root port
// and once to take over inferior ports, and a third walk sends. At most eight
// beats go out per item. Each result beat is held in an output register until
// taken, and the walk waits for it.
module spanning_tree_bpdu_engine #(
	parameter int unsigned MAX_PORTS = stb_pkg::DefMaxPorts
) (
	input logic clk,
	input logic arst_n,
	stb_in_if.sink     in_ch,
	stb_out_if.source  out_ch,
	stb_cfg_if.sink    cfg
);
	import stb_pkg::*;

	localparam int unsigned PW = $clog2(MAX_PORTS);
	localparam int unsigned CW = $clog2(MAX_PORTS + 1);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_INIT   = 10'b0000000010,
		ST_RXCMP  = 10'b0000000100,
		ST_RXSTO  = 10'b0000001000,
		ST_SEL    = 10'b0000010000,
		ST_SELFIN = 10'b0000100000,
		ST_TAKE   = 10'b0001000000,
		ST_SCAN   = 10'b0010000000,
		ST_EMIT   = 10'b0100000000,
		ST_TICK   = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [63:0] bridge_id_q;
	logic [7:0]  port_prio_q;
	logic [15:0] hop_cost_q;
	logic [3:0]  ports_use_q;
	logic [31:0] hello_intv_q;

	// port table
	logic [63:0] port_root_q   [MAX_PORTS];
	logic [31:0] port_cost_q   [MAX_PORTS];
	logic [63:0] port_bridge_q [MAX_PORTS];
	logic [15:0] port_sender_q [MAX_PORTS];

	logic [63:0] root_now_q;
	logic [31:0] root_cost_q;
	logic [PW-1:0] root_idx_q;
	logic        root_vld_q;
	logic        hello_run_q;
	logic [31:0] hello_cnt_q;

	in_item_t    item_q;
	logic [CW-1:0] idx_q;
	logic        send_all_q;
	logic [3:0]  sent_q;
	logic [PW-1:0] pend_q;
	logic        pend_vld_q;
	logic        cmp_better_q;
	logic        out_vld_q;
	out_item_t   out_q;

	logic [CW-1:0] np;
	always_comb begin
		if (32'(ports_use_q) > MAX_PORTS)
			np = CW'(MAX_PORTS);
		else
			np = CW'(ports_use_q);
	end

	function automatic logic [15:0] own_id(input logic [7:0] prio, input logic [PW-1:0] i);
		logic [7:0] low;
		low = 8'(i) + 8'd1;
		return {prio, low};
	endfunction

	// shared comparator: a strictly better than b
	logic [63:0] a_r, b_r;
	logic [31:0] a_c, b_c;
	logic [15:0] a_b, b_b;
	logic [7:0]  a_p, b_p;
	logic        a_better;
	always_comb begin
		if (a_r != b_r)      a_better = a_r < b_r;
		else if (a_c != b_c) a_better = a_c < b_c;
		else if (a_b != b_b) a_better = a_b < b_b;
		else                 a_better = a_p < b_p;
	end

	logic [PW-1:0] cur;
	logic [PW-1:0] rxp;
	assign cur = idx_q[PW-1:0];
	assign rxp = PW'(item_q.rx_port);

	logic [15:0] cur_id;
	assign cur_id = own_id(port_prio_q, cur);

	logic cur_desig;
	assign cur_desig = port_bridge_q[cur] == bridge_id_q &&
		port_sender_q[cur] == cur_id;

	always_comb begin
		a_r = '0; a_c = '0; a_b = '0; a_p = '0;
		b_r = '0; b_c = '0; b_b = '0; b_p = '0;
		unique case (state_q)
			ST_RXCMP: begin
				a_r = item_q.msg_root_id; a_c = item_q.msg_root_cost;
				a_b = item_q.msg_bridge_id[15:0]; a_p = item_q.msg_port_id[7:0];
				b_r = port_root_q[rxp]; b_c = port_cost_q[rxp];
				b_b = port_bridge_q[rxp][15:0]; b_p = port_sender_q[rxp][7:0];
			end
			ST_SEL: begin
				a_r = port_root_q[cur]; a_c = port_cost_q[cur];
				a_b = port_bridge_q[cur][15:0]; a_p = port_sender_q[cur][7:0];
				b_r = port_root_q[root_idx_q]; b_c = port_cost_q[root_idx_q];
				b_b = port_bridge_q[root_idx_q][15:0];
				b_p = port_sender_q[root_idx_q][7:0];
			end
			ST_TAKE: begin
				a_r = root_now_q; a_c = root_cost_q;
				a_b = bridge_id_q[15:0]; a_p = cur_id[7:0];
				b_r = port_root_q[cur]; b_c = port_cost_q[cur];
				b_b = port_bridge_q[cur][15:0]; b_p = port_sender_q[cur][7:0];
			end
			default: ;
		endcase
	end

	logic can_send;
	assign can_send = root_now_q == bridge_id_q || root_vld_q;
	logic out_free;
	assign out_free = !out_vld_q || out_ch.ready;

	// at most eight beats per item, counting the one held back for the last mark
	logic cap_ok;
	assign cap_ok = (sent_q + 4'(pend_vld_q)) < 4'd8;

	logic emit_mid;
	logic emit_end;
	assign emit_mid = state_q == ST_SCAN && idx_q < np && cur_desig && can_send &&
		cap_ok && pend_vld_q && out_free;
	assign emit_end = state_q == ST_EMIT && (send_all_q || can_send) && out_free;

	assign in_ch.ready  = state_q == ST_IDLE;
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = out_vld_q;
	assign out_ch.payload = out_q;

	logic [31:0] lim;
	assign lim = hello_intv_q == '0 ? 32'd1 : hello_intv_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bridge_id_q  <= '0;
			port_prio_q  <= 8'd128;
			hop_cost_q   <= 16'd1;
			ports_use_q  <= 4'd8;
			hello_intv_q <= 32'd2000;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				REG_BRIDGE_ID:  bridge_id_q  <= cfg.payload.data;
				REG_PORT_PRIO:  port_prio_q  <= cfg.payload.data[7:0];
				REG_PATH_COST:  hop_cost_q   <= cfg.payload.data[15:0];
				REG_PORTS_USE:  ports_use_q  <= cfg.payload.data[3:0];
				REG_HELLO_INTV: hello_intv_q <= cfg.payload.data[31:0];
				default: ;
			endcase
		end
	end

	// port table, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PORTS; i++) begin
				port_root_q[i] <= '0; port_cost_q[i] <= '0;
				port_bridge_q[i] <= '0; port_sender_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_INIT: begin
					port_root_q[cur]   <= bridge_id_q;
					port_cost_q[cur]   <= '0;
					port_bridge_q[cur] <= bridge_id_q;
					port_sender_q[cur] <= own_id(port_prio_q, cur);
				end
				ST_RXSTO: if (cmp_better_q) begin
					port_root_q[rxp]   <= item_q.msg_root_id;
					port_cost_q[rxp]   <= item_q.msg_root_cost;
					port_bridge_q[rxp] <= item_q.msg_bridge_id;
					port_sender_q[rxp] <= item_q.msg_port_id;
				end
				ST_TAKE: if (idx_q < np) begin
					if (cur_desig) begin
						port_root_q[cur] <= root_now_q;
						port_cost_q[cur] <= root_cost_q;
					end else if (a_better) begin
						port_root_q[cur]   <= root_now_q;
						port_cost_q[cur]   <= root_cost_q;
						port_bridge_q[cur] <= bridge_id_q;
						port_sender_q[cur] <= own_id(port_prio_q, cur);
					end
				end
				default: ;
			endcase
		end
	end

	// output register: load a beat, or drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_mid || emit_end) begin
			out_vld_q <= 1'b1;
			out_q <= '{3'(pend_q), root_now_q, root_cost_q,
				bridge_id_q, own_id(port_prio_q, pend_q), emit_end};
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_now_q  <= '0;
			root_cost_q <= '0;
			root_idx_q  <= '0;
			root_vld_q  <= 1'b0;
			hello_run_q <= 1'b0;
			hello_cnt_q <= '0;
			idx_q       <= '0;
			send_all_q  <= 1'b0;
			sent_q      <= '0;
			pend_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					item_q <= in_ch.payload;
					idx_q  <= '0;
					unique case (in_ch.payload.op)
						OP_START: state_q <= ST_INIT;
						OP_RX: state_q <= (32'(in_ch.payload.rx_port) < 32'(np)) ?
							ST_RXCMP : ST_IDLE;
						OP_TICK: state_q <= ST_TICK;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_INIT: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == CW'(MAX_PORTS - 1)) begin
						root_now_q  <= bridge_id_q;
						root_cost_q <= '0;
						root_vld_q  <= 1'b0;
						root_idx_q  <= '0;
						hello_run_q <= 1'b1;
						hello_cnt_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_TICK: begin
					state_q <= ST_IDLE;
					if (hello_run_q) begin
						if (hello_cnt_q + 32'd1 >= lim) begin
							hello_cnt_q <= '0;
							idx_q <= '0; sent_q <= '0; pend_vld_q <= 1'b0;
							send_all_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							hello_cnt_q <= hello_cnt_q + 32'd1;
						end
					end
				end
				ST_RXCMP: begin
					cmp_better_q <= a_better;
					state_q <= ST_RXSTO;
				end
				ST_RXSTO: begin
					sent_q <= '0; pend_vld_q <= 1'b0; idx_q <= '0;
					if (cmp_better_q) begin
						if (root_now_q == bridge_id_q) hello_run_q <= 1'b0;
						root_vld_q <= 1'b0; root_idx_q <= '0;
						state_q <= ST_SEL;
					end else begin
						send_all_q <= 1'b0;
						state_q <= ST_EMIT;
						pend_q <= rxp;
						pend_vld_q <= 1'b0;
					end
				end
				ST_SEL: begin
					if (idx_q < np) begin
						if (!cur_desig && (!root_vld_q || a_better)) begin
							root_idx_q <= cur;
							root_vld_q <= 1'b1;
						end
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= ST_SELFIN;
					end
				end
				ST_SELFIN: begin
					if (!root_vld_q) begin
						root_now_q <= bridge_id_q; root_cost_q <= '0;
					end else begin
						root_now_q  <= port_root_q[root_idx_q];
						root_cost_q <= port_cost_q[root_idx_q] + 32'(hop_cost_q);
					end
					idx_q <= '0;
					state_q <= ST_TAKE;
				end
				ST_TAKE: begin
					if (idx_q < np) idx_q <= idx_q + CW'(1);
					else begin
						idx_q <= '0; send_all_q <= 1'b1; state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// look ahead one designated port so the final beat is marked
					if (idx_q < np) begin
						if (cur_desig && can_send && cap_ok) begin
							if (pend_vld_q) begin
								if (out_free) begin
									sent_q <= sent_q + 4'd1;
									pend_q <= cur;
									idx_q <= idx_q + CW'(1);
								end
							end else begin
								pend_q <= cur; pend_vld_q <= 1'b1;
								idx_q <= idx_q + CW'(1);
							end
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end else if (pend_vld_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!send_all_q && !can_send) state_q <= ST_IDLE;
					else if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: sv/stb_checker.sv
// Port-level checker for the engine, bound to the top level.
`include "spanning_tree_bpdu_engine_defines.svh"
module stb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic [1:0] in_op
);
	import stb_pkg::*;
	// a start item never yields a beat right after it is taken
	`STB_ASSERT_NEXT(a_start_quiet, clk, arst_n,
		in_valid && in_ready && in_op == OP_START && !out_valid, !out_valid,
		"beat after start item")
	// a stalled beat is held
	`STB_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"beat dropped while stalled")
	// the block is busy in the cycle after taking a start or tick item
	`STB_ASSERT_NEXT(a_busy, clk, arst_n,
		in_valid && in_ready && (in_op == OP_START || in_op == OP_TICK), !in_ready,
		"ready right after accept")
	// hold the last mark of a stalled beat
	`STB_ASSERT_NEXT(a_last_hold, clk, arst_n, out_valid && !out_ready && out_last, out_last,
		"last mark changed while stalled")
endmodule

bind spanning_tree_bpdu_engine stb_checker u_stb_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_last(out_ch.payload.last), .in_op(in_ch.payload.op)
);
